[rtl/nnis_pkg.sv]
// Package for the nearest-neighbour image scaler.
// Holds the payload structs, opcodes, register indexes, reset values and the size clamp.
// No dependencies.
`default_nettype none

package nnis_pkg;

  localparam int NNIS_CFG_W      = 12;
  localparam int NNIS_PIX_W      = 32;
  localparam int NNIS_MAX_WIDTH  = 2048;
  localparam int NNIS_MAX_HEIGHT = 2048;

  localparam logic [NNIS_CFG_W-1:0] NNIS_RST_SRC_WIDTH  = 12'd640;
  localparam logic [NNIS_CFG_W-1:0] NNIS_RST_SRC_HEIGHT = 12'd480;
  localparam logic [NNIS_CFG_W-1:0] NNIS_RST_DST_WIDTH  = 12'd640;
  localparam logic [NNIS_CFG_W-1:0] NNIS_RST_DST_HEIGHT = 12'd480;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_COL_START,
    PH_COL_WAIT,
    PH_ROW_START,
    PH_ROW_WAIT,
    PH_RUN
  } map_phase_t;

  typedef struct packed {
    logic                  operation;
    logic [NNIS_PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [NNIS_PIX_W-1:0] pixel_out;
    logic                  end_of_row;
    logic                  end_of_frame;
  } out_item_t;

  // A size of zero counts as one, and a size above the maximum as the maximum.
  function automatic logic [NNIS_CFG_W-1:0] clamp_size(input logic [NNIS_CFG_W-1:0] v,
                                                       input logic [31:0] mx);
    logic [31:0] v_ext;
    v_ext = {{(32-NNIS_CFG_W){1'b0}}, v};
    if (v == '0) begin
      return NNIS_CFG_W'(1);
    end else if (v_ext > mx) begin
      return mx[NNIS_CFG_W-1:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/nnis_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/nnis_divider.sv]
// Restoring divider, one quotient bit per cycle, for the scale step set-up.
// Depends on nothing outside this file.
`default_nettype none

module nnis_divider #(
  parameter int W = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     num;
  logic [W-1:0]     den;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {remainder, num[W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(W);
        num       <= dividend;
        den       <= divisor;
        remainder <= '0;
        quotient  <= '0;
      end else if (busy) begin
        num <= {num[W-2:0], 1'b0};
        if (!diff[W]) begin
          remainder <= diff[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b1};
        end else begin
          remainder <= shifted[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nearest_neighbor_image_scaler.sv]
// Nearest-neighbour image scaler: one-row line store, push source pixels, pull scaled pixels.
// Throughput is one item per cycle while the set-up is done and the result queue has room; a
// result passes through the registered read of the line store and then the result queue.
// After reset and after every register write, a set-up divides the sizes into column and
// row scale steps on a shared bit-serial divider; no item is taken meanwhile. Reset restores
// the default sizes and clears all counters; the line store keeps its contents.
// Depends on nnis_pkg, nnis_ram and nnis_divider.
`default_nettype none

module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_WIDTH = NNIS_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [NNIS_CFG_W-1:0] cfg_data
);

  localparam int W     = NNIS_CFG_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int QD    = 4;
  localparam int QP_W  = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  logic [W-1:0] src_width, src_height, dst_width, dst_height;
  logic [W-1:0] sw, sh, dw, dh;

  logic [W-1:0] src_col, src_row, dst_col, dst_row;
  logic [W-1:0] src_col_next, src_row_next, dst_col_next, dst_row_next;
  logic         row_ready, row_ready_next, draining, draining_next;
  logic [W-1:0] xq, xr, yq, yr;
  logic [W-1:0] xq_next, xr_next, yq_next, yr_next;
  logic [W-1:0] qw, rw, qh, rh;

  map_phase_t   phase, phase_next;
  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, div_q, div_r;

  logic         in_fire, cfg_fire, pop;
  logic         is_pull, mem_we, mem_re;
  logic [31:0]  mem_rdata;

  logic         s1_valid, s1_acc, s1_pull, s1_eor, s1_eof;
  logic         s1_acc_next, s1_eor_next, s1_eof_next;

  out_item_t       q [QD];
  logic [QP_W-1:0] head, tail;
  logic [QC_W-1:0] count;
  out_item_t       s1_res;

  logic [W:0]   src_col_inc, src_row_inc, dst_col_inc, dst_row_inc;
  logic [W-1:0] src_row_wrap;
  logic [W:0]   xr_sum, yr_sum;
  logic         x_carry, y_carry;
  logic [W-1:0] xq_adv, xr_adv, yq_adv, yr_adv;

  assign sw = clamp_size(src_width, 32'(MAX_WIDTH));
  assign sh = clamp_size(src_height, 32'(NNIS_MAX_HEIGHT));
  assign dw = clamp_size(dst_width, 32'(MAX_WIDTH));
  assign dh = clamp_size(dst_height, 32'(NNIS_MAX_HEIGHT));

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (phase == PH_RUN) && ({{(QC_W-1){1'b0}}, s1_valid} + count < QC_W'(QD));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_data  = q[head];
  assign pop       = out_valid && out_ready;
  assign is_pull   = (in_data.operation == OP_PULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= NNIS_RST_SRC_WIDTH;
      src_height <= NNIS_RST_SRC_HEIGHT;
      dst_width  <= NNIS_RST_DST_WIDTH;
      dst_height <= NNIS_RST_DST_HEIGHT;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        CFG_DST_WIDTH:  dst_width  <= cfg_data;
        CFG_DST_HEIGHT: dst_height <= cfg_data;
        default:        src_width  <= src_width;
      endcase
    end
  end

  // Scale step set-up: column step sw/dw first, then row step sh/dh.
  always_comb begin
    phase_next = phase;
    div_start  = 1'b0;
    div_a      = sw;
    div_b      = dw;
    case (phase)
      PH_COL_START: begin
        div_start  = 1'b1;
        phase_next = PH_COL_WAIT;
      end
      PH_COL_WAIT: begin
        if (div_done) begin
          phase_next = PH_ROW_START;
        end
      end
      PH_ROW_START: begin
        div_start  = 1'b1;
        div_a      = sh;
        div_b      = dh;
        phase_next = PH_ROW_WAIT;
      end
      PH_ROW_WAIT: begin
        if (div_done) begin
          phase_next = PH_RUN;
        end
      end
      PH_RUN: begin
        phase_next = PH_RUN;
      end
      default: begin
        phase_next = PH_COL_START;
      end
    endcase
    if (cfg_fire) begin
      phase_next = PH_COL_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COL_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_COL_WAIT && div_done) begin
      qw <= div_q;
      rw <= div_r;
    end
    if (phase == PH_ROW_WAIT && div_done) begin
      qh <= div_q;
      rh <= div_r;
    end
  end

  nnis_divider #(
    .W (W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Incremental floor(i * num / den): add the step, carry once when the remainder overflows.
  assign xr_sum  = {1'b0, xr} + {1'b0, rw};
  assign x_carry = (xr_sum >= {1'b0, dw});
  assign xr_adv  = x_carry ? W'(xr_sum - {1'b0, dw}) : xr_sum[W-1:0];
  assign xq_adv  = xq + qw + W'(x_carry);

  assign yr_sum  = {1'b0, yr} + {1'b0, rh};
  assign y_carry = (yr_sum >= {1'b0, dh});
  assign yr_adv  = y_carry ? W'(yr_sum - {1'b0, dh}) : yr_sum[W-1:0];
  assign yq_adv  = yq + qh + W'(y_carry);

  assign src_col_inc  = {1'b0, src_col} + (W+1)'(1);
  assign src_row_inc  = {1'b0, src_row} + (W+1)'(1);
  assign dst_col_inc  = {1'b0, dst_col} + (W+1)'(1);
  assign dst_row_inc  = {1'b0, dst_row} + (W+1)'(1);
  assign src_row_wrap = (src_row_inc >= {1'b0, sh}) ? '0 : src_row_inc[W-1:0];

  assign mem_we = in_fire && !is_pull && !row_ready;
  assign mem_re = in_fire && is_pull && row_ready;

  always_comb begin
    src_col_next   = src_col;
    src_row_next   = src_row;
    dst_col_next   = dst_col;
    dst_row_next   = dst_row;
    row_ready_next = row_ready;
    draining_next  = draining;
    xq_next        = xq;
    xr_next        = xr;
    yq_next        = yq;
    yr_next        = yr;
    s1_acc_next    = 1'b0;
    s1_eor_next    = 1'b0;
    s1_eof_next    = 1'b0;
    if (cfg_fire) begin
      src_col_next   = '0;
      src_row_next   = '0;
      dst_col_next   = '0;
      dst_row_next   = '0;
      row_ready_next = 1'b0;
      draining_next  = 1'b0;
      xq_next        = '0;
      xr_next        = '0;
      yq_next        = '0;
      yr_next        = '0;
    end else if (mem_we) begin
      s1_acc_next = 1'b1;
      if (src_col_inc >= {1'b0, sw}) begin
        src_col_next = '0;
        if (draining) begin
          src_row_next = src_row_wrap;
          if (src_row_inc >= {1'b0, sh}) begin
            draining_next = 1'b0;
          end
        end else if (yq == src_row) begin
          row_ready_next = 1'b1;
        end else begin
          src_row_next = src_row_wrap;
        end
      end else begin
        src_col_next = src_col_inc[W-1:0];
      end
    end else if (mem_re) begin
      s1_acc_next = 1'b1;
      if (dst_col_inc < {1'b0, dw}) begin
        dst_col_next = dst_col_inc[W-1:0];
        xq_next      = xq_adv;
        xr_next      = xr_adv;
      end else begin
        s1_eor_next  = 1'b1;
        dst_col_next = '0;
        xq_next      = '0;
        xr_next      = '0;
        if (dst_row_inc >= {1'b0, dh}) begin
          s1_eof_next    = 1'b1;
          dst_row_next   = '0;
          yq_next        = '0;
          yr_next        = '0;
          row_ready_next = 1'b0;
          src_row_next   = src_row_wrap;
          draining_next  = (src_row_inc < {1'b0, sh});
        end else begin
          dst_row_next = dst_row_inc[W-1:0];
          yq_next      = yq_adv;
          yr_next      = yr_adv;
          if (yq_adv != src_row) begin
            row_ready_next = 1'b0;
            src_row_next   = src_row_wrap;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col   <= '0;
      src_row   <= '0;
      dst_col   <= '0;
      dst_row   <= '0;
      row_ready <= 1'b0;
      draining  <= 1'b0;
      xq        <= '0;
      xr        <= '0;
      yq        <= '0;
      yr        <= '0;
      s1_valid  <= 1'b0;
    end else begin
      src_col   <= src_col_next;
      src_row   <= src_row_next;
      dst_col   <= dst_col_next;
      dst_row   <= dst_row_next;
      row_ready <= row_ready_next;
      draining  <= draining_next;
      xq        <= xq_next;
      xr        <= xr_next;
      yq        <= yq_next;
      yr        <= yr_next;
      s1_valid  <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_acc  <= s1_acc_next;
    s1_pull <= is_pull;
    s1_eor  <= s1_eor_next;
    s1_eof  <= s1_eof_next;
  end

  nnis_ram #(
    .WIDTH (NNIS_PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (COL_W'(src_col)),
    .wdata (in_data.pixel_in),
    .re    (mem_re),
    .raddr (COL_W'(xq)),
    .rdata (mem_rdata)
  );

  always_comb begin
    s1_res.accepted     = s1_acc;
    s1_res.pixel_out    = (s1_acc && s1_pull) ? mem_rdata : '0;
    s1_res.end_of_row   = s1_eor;
    s1_res.end_of_frame = s1_eof;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q[tail] <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (s1_valid) begin
        tail <= tail + QP_W'(1);
      end
      if (pop) begin
        head <= head + QP_W'(1);
      end
      count <= count + QC_W'(s1_valid) - QC_W'(pop);
    end
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(count == QC_W'(QD) && s1_valid && !pop))
    else $error("result queue overflow");

  a_refused_push_stable: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_pull && row_ready && !cfg_fire) |=>
      ($stable(src_col) && $stable(src_row) && $stable(row_ready)))
    else $error("refused push changed the source position");

  a_read_in_row: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (xq < sw))
    else $error("line store read beyond the source row");

  a_dest_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUN) |-> ((dst_col < dw) && (dst_row < dh) && (src_row < sh)))
    else $error("counter outside the frame");

endmodule

`default_nettype wire
